// ----- sv/thm_pkg.sv -----
// ============================================================================
// thm_pkg
// Shared types, constants and the fixed resistance table of the thermistor
// converter.
// ============================================================================
package thm_pkg;

    localparam int CFG_W      = 12;   // full-scale register width
    localparam int CFG_EXT_W  = 16;   // widest sample the block supports
    localparam int RES_W      = 24;   // Q14.10 kohm
    localparam int TEMP_W     = 15;   // Q7.8 degrees C
    localparam int FRAC_BITS  = 11;   // interpolation quotient never exceeds 1280
    localparam int UNIT_W     = 36;   // shared subtractor width
    localparam int ROM_IDX_W  = 6;    // table index, up to 64 entries

    localparam logic [CFG_W-1:0]  FS_RESET = 12'd4095;
    localparam logic [RES_W-1:0]  RES_MAX  = 24'hFFFFFF;
    localparam logic [TEMP_W-1:0] TEMP_MAX = 15'h7FFF;
    localparam logic [TEMP_W-1:0] HOT_TEMP = 15'd28160;
    localparam logic [TEMP_W-1:0] TEMP_ZERO = 15'd0;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_COLD   = 2'd1;
    localparam logic [1:0] REGION_HOT    = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] diff;
        logic              ge;     // a >= b, no borrow
    } sub_res_t;

    // Resistance in Q14.10 kohm; entry i stands for 5*i degrees C.
    function automatic logic [RES_W-1:0] table_entry(input logic [ROM_IDX_W-1:0] idx);
        logic [RES_W-1:0] val;
        case (idx)
            6'd0:    val = 24'd33751;
            6'd1:    val = 24'd26194;
            6'd2:    val = 24'd20480;
            6'd3:    val = 24'd16138;
            6'd4:    val = 24'd12810;
            6'd5:    val = 24'd10240;
            6'd6:    val = 24'd8241;
            6'd7:    val = 24'd6674;
            6'd8:    val = 24'd5439;
            6'd9:    val = 24'd4458;
            6'd10:   val = 24'd3674;
            6'd11:   val = 24'd3045;
            6'd12:   val = 24'd2535;
            6'd13:   val = 24'd2122;
            6'd14:   val = 24'd1785;
            6'd15:   val = 24'd1471;
            6'd16:   val = 24'd1280;
            6'd17:   val = 24'd1091;
            6'd18:   val = 24'd933;
            6'd19:   val = 24'd801;
            6'd20:   val = 24'd691;
            6'd21:   val = 24'd598;
            6'd22:   val = 24'd519;
            default: val = 24'd0;
        endcase
        return val;
    endfunction

endpackage

// ----- sv/thm_sub_unit.sv -----
// ============================================================================
// thm_sub_unit
// Shared subtract and compare unit, time-multiplexed by the sequencer.
// ============================================================================
module thm_sub_unit (
    input  logic [thm_pkg::UNIT_W-1:0] a,
    input  logic [thm_pkg::UNIT_W-1:0] b,
    output thm_pkg::sub_res_t          res
);

    logic [thm_pkg::UNIT_W:0] full;

    assign full     = {1'b0, a} - {1'b0, b};
    assign res.diff = full[thm_pkg::UNIT_W-1:0];
    assign res.ge   = ~full[thm_pkg::UNIT_W];

endmodule

// ----- sv/thermistor_adc_to_temperature.sv -----
// ============================================================================
// thermistor_adc_to_temperature
// Converts one thermistor divider ADC sample to resistance and temperature.
// ============================================================================
// Pulse start while busy is low to hand over one sample. The block then runs
// one subtract/compare unit under a sequencer and raises done for exactly one
// cycle with temperature_q8, resistance_q10 and region; the receiver has no
// way to stall, so capture the result on that cycle. A sample runs through
// a clamp step, the bit-serial resistance division, removal of the series
// resistor, the cold and hot checks, the linear table scan over 1 to
// TABLE_ENTRIES-1 segments, the bit-serial interpolation division and the
// temperature step, all sharing the one unit.
// Cold and hot readings finish early. busy drops on the cycle done is high,
// so the next start may be taken right then. Write adc_full_scale through the
// cfg channel only while busy is low; cfg_ready is always high.
// ============================================================================
module thermistor_adc_to_temperature #(
    parameter int TABLE_ENTRIES = 23,
    parameter int ADC_BITS      = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ADC_BITS-1:0]          adc_sample,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [thm_pkg::CFG_W-1:0]    cfg_data,
    output logic                         done,
    output logic [thm_pkg::TEMP_W-1:0]   temperature_q8,
    output logic [thm_pkg::RES_W-1:0]    resistance_q10,
    output logic [1:0]                   region
);

    localparam int NUM_W = ADC_BITS + 10;          // quotient bits of fs*1024/s
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(NUM_W);
    localparam int UW    = thm_pkg::UNIT_W;
    localparam int RW    = thm_pkg::RES_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] SEG_END  = IDX_W'(TABLE_ENTRIES - 2);
    localparam logic [CNT_W-1:0] DIV_END  = CNT_W'(NUM_W - 1);
    localparam logic [CNT_W-1:0] FRAC_END = CNT_W'(thm_pkg::FRAC_BITS - 1);
    localparam logic [UW-1:0]    ONE_KOHM = UW'(1024);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLAMP = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_RFIX  = 4'd3;
    localparam logic [3:0] ST_COLD  = 4'd4;
    localparam logic [3:0] ST_HOT   = 4'd5;
    localparam logic [3:0] ST_SEG   = 4'd6;
    localparam logic [3:0] ST_DPREP = 4'd7;
    localparam logic [3:0] ST_DIV2  = 4'd8;
    localparam logic [3:0] ST_TEMP  = 4'd9;

    logic [3:0]                  state_reg, state_next;
    logic [thm_pkg::CFG_W-1:0]   fs_cfg_reg;
    logic [ADC_BITS-1:0]         fs_reg, s_reg;
    logic [UW-1:0]               rem_reg, dsh_reg;
    logic [NUM_W-1:0]            q_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [RW-1:0]               res_reg, rl_reg;
    logic [IDX_W-1:0]            seg_reg;
    logic                        lt_hi_reg;
    logic                        done_reg;
    logic [thm_pkg::TEMP_W-1:0]  temp_out_reg;
    logic [RW-1:0]               res_out_reg;
    logic [1:0]                  region_out_reg;

    logic [thm_pkg::CFG_EXT_W-1:0] fs_ext;
    logic [ADC_BITS-1:0]           fs_mask, fs_eff;
    logic [ADC_BITS:0]             trial;
    logic [IDX_W:0]                seg_p1;
    logic [RW-1:0]                 tab_hi, tab_lo, tab_first, tab_last;
    logic [UW-1:0]                 op_a, op_b, temp_base;
    thm_pkg::sub_res_t             sub;

    // Effective full scale: keep the sample's width, treat zero as one.
    assign fs_ext  = thm_pkg::CFG_EXT_W'(fs_cfg_reg);
    assign fs_mask = fs_ext[ADC_BITS-1:0];
    assign fs_eff  = (fs_mask == '0) ? ADC_BITS'(1) : fs_mask;

    // Next dividend bit shifts into the partial remainder.
    assign trial  = {rem_reg[ADC_BITS-1:0], q_reg[NUM_W-1]};
    assign seg_p1 = (IDX_W+1)'(seg_reg) + (IDX_W+1)'(1);

    assign tab_hi    = thm_pkg::table_entry(thm_pkg::ROM_IDX_W'(seg_reg));
    assign tab_lo    = thm_pkg::table_entry(thm_pkg::ROM_IDX_W'(seg_p1));
    assign tab_first = thm_pkg::table_entry(thm_pkg::ROM_IDX_W'(0));
    assign tab_last  = thm_pkg::table_entry(thm_pkg::ROM_IDX_W'(LAST_IDX));

    // 1280 * (segment + 1), the hot edge of the matched segment
    assign temp_base = (UW'(seg_p1) << 10) + (UW'(seg_p1) << 8);

    // Route operands to the shared unit for the current step.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_CLAMP: begin op_a = UW'(fs_reg);    op_b = UW'(s_reg);  end
            ST_DIV:   begin op_a = UW'(trial);     op_b = UW'(s_reg);  end
            ST_RFIX:  begin op_a = UW'(q_reg);     op_b = ONE_KOHM;    end
            ST_COLD:  begin op_a = UW'(tab_first); op_b = UW'(res_reg); end
            ST_HOT:   begin op_a = UW'(tab_last);  op_b = UW'(res_reg); end
            ST_SEG:   begin op_a = UW'(res_reg);   op_b = UW'(tab_lo); end
            ST_DPREP: begin op_a = UW'(tab_hi);    op_b = UW'(tab_lo); end
            ST_DIV2:  begin op_a = rem_reg;        op_b = dsh_reg;     end
            ST_TEMP:
            begin
                op_a = temp_base;
                op_b = UW'(q_reg[thm_pkg::FRAC_BITS-1:0]);
            end
            default:  begin op_a = '0;             op_b = '0;          end
        endcase
    end

    thm_sub_unit u_sub (
        .a   (op_a),
        .b   (op_b),
        .res (sub)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_CLAMP;
            ST_CLAMP: state_next = (sub.ge && s_reg == '0) ? ST_COLD : ST_DIV;
            ST_DIV:   if (cnt_reg == DIV_END) state_next = ST_RFIX;
            ST_RFIX:  state_next = ST_COLD;
            ST_COLD:  state_next = sub.ge ? ST_HOT : ST_IDLE;
            ST_HOT:   state_next = sub.ge ? ST_IDLE : ST_SEG;
            ST_SEG:
            begin
                if (sub.ge && lt_hi_reg)
                    state_next = ST_DPREP;
                else if (seg_reg == SEG_END)
                    state_next = ST_IDLE;
            end
            ST_DPREP: state_next = ST_DIV2;
            ST_DIV2:  if (cnt_reg == FRAC_END) state_next = ST_TEMP;
            ST_TEMP:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fs_cfg_reg <= thm_pkg::FS_RESET;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                fs_cfg_reg <= cfg_data;
            // Raise done on the cycle after the last step; drop it after one.
            unique case (state_reg)
                ST_COLD:  done_reg <= !sub.ge;
                ST_HOT:   done_reg <= sub.ge;
                ST_SEG:   done_reg <= !(sub.ge && lt_hi_reg) && (seg_reg == SEG_END);
                ST_TEMP:  done_reg <= 1'b1;
                default:  done_reg <= 1'b0;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    s_reg  <= adc_sample;
                    fs_reg <= fs_eff;
                end
            end
            ST_CLAMP:
            begin
                // Clamp a sample above full scale to full scale.
                if (!sub.ge)
                    s_reg <= fs_reg;
                if (sub.ge && s_reg == '0)
                    res_reg <= thm_pkg::RES_MAX;
                rem_reg <= '0;
                q_reg   <= {fs_reg, 10'b0};
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= sub.ge ? sub.diff : UW'(trial);
                q_reg   <= {q_reg[NUM_W-2:0], sub.ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_RFIX:
            begin
                // Drop the 1 kohm series resistor and saturate.
                if (|sub.diff[UW-1:RW])
                    res_reg <= thm_pkg::RES_MAX;
                else
                    res_reg <= sub.diff[RW-1:0];
            end
            ST_COLD:
            begin
                res_out_reg <= res_reg;
                if (!sub.ge)
                begin
                    temp_out_reg   <= thm_pkg::TEMP_ZERO;
                    region_out_reg <= thm_pkg::REGION_COLD;
                end
                // Equal to the first entry fails every segment's upper bound.
                lt_hi_reg <= (sub.diff != '0);
            end
            ST_HOT:
            begin
                if (sub.ge)
                begin
                    temp_out_reg   <= thm_pkg::HOT_TEMP;
                    region_out_reg <= thm_pkg::REGION_HOT;
                end
                seg_reg <= '0;
            end
            ST_SEG:
            begin
                if (sub.ge && lt_hi_reg)
                    rl_reg <= sub.diff[RW-1:0];
                else
                begin
                    lt_hi_reg <= ~sub.ge;
                    seg_reg   <= seg_reg + IDX_W'(1);
                    temp_out_reg   <= thm_pkg::TEMP_ZERO;
                    region_out_reg <= thm_pkg::REGION_INSIDE;
                end
            end
            ST_DPREP:
            begin
                // 2560*(R - lo) + d over divisor 2d, rounding half up
                rem_reg <= (UW'(rl_reg) << 11) + (UW'(rl_reg) << 9)
                           + UW'(sub.diff[RW-1:0]);
                dsh_reg <= UW'(sub.diff[RW-1:0]) << (thm_pkg::FRAC_BITS);
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV2:
            begin
                if (sub.ge)
                    rem_reg <= sub.diff;
                q_reg   <= {q_reg[NUM_W-2:0], sub.ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            ST_TEMP:
            begin
                if (|sub.diff[UW-1:thm_pkg::TEMP_W])
                    temp_out_reg <= thm_pkg::TEMP_MAX;
                else
                    temp_out_reg <= sub.diff[thm_pkg::TEMP_W-1:0];
                region_out_reg <= thm_pkg::REGION_INSIDE;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign done           = done_reg;
    assign temperature_q8 = temp_out_reg;
    assign resistance_q10 = res_out_reg;
    assign region         = region_out_reg;

endmodule

// ----- sv/thm_checker.sv -----
// ============================================================================
// thm_checker
// Port-level checks of the thermistor converter, bound to the top level.
// ============================================================================
module thm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [thm_pkg::TEMP_W-1:0] temperature_q8,
    input logic [1:0]                 region
);

    // An accepted transaction keeps the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // Results come as single-cycle pulses.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_cold_temp: assert property (@(posedge clk) disable iff (!rst_n)
        done && region == thm_pkg::REGION_COLD |-> temperature_q8 == thm_pkg::TEMP_ZERO)
        else $error("cold reading with nonzero temperature");

    a_hot_temp: assert property (@(posedge clk) disable iff (!rst_n)
        done && region == thm_pkg::REGION_HOT |-> temperature_q8 == thm_pkg::HOT_TEMP)
        else $error("hot reading not at table top temperature");

    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> region == thm_pkg::REGION_INSIDE || region == thm_pkg::REGION_COLD
                 || region == thm_pkg::REGION_HOT)
        else $error("undefined region code");

endmodule

bind thermistor_adc_to_temperature thm_checker u_thm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .temperature_q8 (temperature_q8),
    .region         (region)
);

// ----- test/thermistor_adc_to_temperature_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// thermistor_adc_to_temperature_tb
// Self-checking bench for the thermistor ADC to temperature converter.
// ============================================================================
// Feed ADC samples through the start/busy handshake and predict resistance,
// temperature and region for each accepted transaction with a local fixed
// point model. Compare every done strobe against the oldest prediction.
// Cover directed corners first (zero sample, clamping above full scale,
// zero full scale, cold and hot ends of the table), then random samples
// under several full-scale settings with bursty and back-to-back traffic.
// ============================================================================
module thermistor_adc_to_temperature_tb;

    localparam int ADC_W          = 12;
    localparam int TABLE_POINTS   = 23;
    localparam int STEP_Q8        = 1280;     // 5 degrees C in Q7.8
    localparam int CLK_HALF_NS    = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int DRAIN_CYCLES   = 80;       // worst-case conversion plus margin
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int RANDOM_PER_SET = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [thm_pkg::TEMP_W-1:0] temp;
        logic [thm_pkg::RES_W-1:0]  res;
        logic [1:0]                 region;
    } reading_t;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [ADC_W-1:0]           adc_sample;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [thm_pkg::CFG_W-1:0]  cfg_data;
    logic                       done;
    logic [thm_pkg::TEMP_W-1:0] temperature_q8;
    logic [thm_pkg::RES_W-1:0]  resistance_q10;
    logic [1:0]                 region;

    thermistor_adc_to_temperature #(
        .TABLE_ENTRIES(TABLE_POINTS),
        .ADC_BITS     (ADC_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .adc_sample    (adc_sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .temperature_q8(temperature_q8),
        .resistance_q10(resistance_q10),
        .region        (region)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [thm_pkg::RES_W-1:0] kohm_table [TABLE_POINTS];  // Q14.10 kohm, entry i = 5*i C
    logic [thm_pkg::CFG_W-1:0] full_scale_shadow;          // mirror of adc_full_scale
    reading_t                  pending_readings [$];       // predictions awaiting done

    int unsigned mismatch_count;
    int unsigned samples_sent;
    int unsigned readings_checked;
    int unsigned inside_seen;
    int unsigned cold_seen;
    int unsigned hot_seen;
    int unsigned scale_writes;

    // ------------------------------------------------------------------------
    // Clock, and a watchdog that ends a hung run
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_HALF_NS) clk = ~clk;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d readings still pending",
                 CYCLE_LIMIT, pending_readings.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        kohm_table = '{33751, 26194, 20480, 16138, 12810, 10240, 8241, 6674,
                       5439, 4458, 3674, 3045, 2535, 2122, 1785, 1471,
                       1280, 1091, 933, 801, 691, 598, 519};
    end

    // ------------------------------------------------------------------------
    // Predict one conversion: resistance = fs*1024/sample - 1024 in Q14.10,
    // then classify against the table and interpolate inside a segment.
    // ------------------------------------------------------------------------
    function automatic reading_t predict_reading(input logic [ADC_W-1:0] sample,
                                                 input logic [thm_pkg::CFG_W-1:0] fs_setting);
        longint unsigned fs;
        longint unsigned s;
        longint unsigned r;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned span;
        longint unsigned frac;
        longint unsigned t;
        reading_t        out;
        bit              found;

        fs = fs_setting;
        s  = sample;
        if (fs == 0)
            fs = 1;                 // zero full scale acts as one
        if (s > fs)
            s = fs;                 // clamp readings above full scale

        if (s == 0)
            r = thm_pkg::RES_MAX;   // open divider: saturate
        else
        begin
            r = ((fs << 10) / s) - 1024;
            if (r > thm_pkg::RES_MAX)
                r = thm_pkg::RES_MAX;
        end

        out.res    = r[thm_pkg::RES_W-1:0];
        out.temp   = thm_pkg::TEMP_ZERO;
        out.region = thm_pkg::REGION_INSIDE;
        found      = 1'b0;

        if (r > kohm_table[0])
            out.region = thm_pkg::REGION_COLD;
        else if (r <= kohm_table[TABLE_POINTS-1])
        begin
            out.temp   = thm_pkg::HOT_TEMP;
            out.region = thm_pkg::REGION_HOT;
        end
        else
        begin
            for (int i = 0; i + 1 < TABLE_POINTS; i++)
            begin
                hi = kohm_table[i];
                lo = kohm_table[i+1];
                if (!found && r >= lo && r < hi)
                begin
                    found = 1'b1;
                    span  = hi - lo;
                    // round half up of 1280*(r-lo)/span
                    frac  = (2 * STEP_Q8 * (r - lo) + span) / (2 * span);
                    t     = STEP_Q8 * (i + 1) - frac;
                    out.temp = (t > thm_pkg::TEMP_MAX) ? thm_pkg::TEMP_MAX
                                                       : t[thm_pkg::TEMP_W-1:0];
                end
            end
        end
        return out;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so take every done strobe
    // and match it against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result: temp=%0d res=%0d region=%0d",
                             $realtime, temperature_q8, resistance_q10, region);
            end
            else
            begin
                want = pending_readings.pop_front();
                readings_checked++;
                case (want.region)
                    thm_pkg::REGION_COLD: cold_seen++;
                    thm_pkg::REGION_HOT:  hot_seen++;
                    default:              inside_seen++;
                endcase
                if (temperature_q8 !== want.temp || resistance_q10 !== want.res ||
                    region !== want.region)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"[%0t] mismatch on reading %0d: ",
                                  "temp exp %0d got %0d, res exp %0d got %0d, ",
                                  "region exp %0d got %0d"},
                                 $realtime, readings_checked,
                                 want.temp, temperature_q8, want.res, resistance_q10,
                                 want.region, region);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Present one sample and hold it until the block takes it; predict the
    // reading with the full scale that is live at acceptance. Leave start
    // high so the next call can chain back to back.
    task automatic send_sample(input logic [ADC_W-1:0] sample);
        start      <= 1'b1;
        adc_sample <= sample;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_readings.push_back(predict_reading(sample, full_scale_shadow));
        samples_sent++;
    endtask

    // Drop start and idle for a number of cycles.
    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop start and wait until every prediction has been matched.
    task automatic drain_readings();
        start <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // Write the full-scale register; only called with the block idle.
    task automatic set_full_scale(input logic [thm_pkg::CFG_W-1:0] value);
        drain_readings();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        full_scale_shadow = value;
        scale_writes++;
    endtask

    // Draw a sample: in four draws of ten a reading that lands inside the table
    // for the current full scale, the rest anywhere, near zero or near full scale.
    function automatic logic [ADC_W-1:0] pick_sample(
        input logic [thm_pkg::CFG_W-1:0] fs_setting);
        int unsigned fs;
        int unsigned lo_s;
        int unsigned hi_s;
        fs = (fs_setting == 0) ? 1 : fs_setting;
        case ($urandom_range(0, 9)) inside
            0, 1:    return ADC_W'($urandom_range(0, (1 << ADC_W) - 1));
            2, 3:    return ADC_W'($urandom_range(0, fs));
            4:       return ADC_W'($urandom_range(0, 8));
            5:
            begin
                lo_s = (fs > 4) ? fs - 4 : 0;
                hi_s = (fs + 4 < (1 << ADC_W)) ? fs + 4 : (1 << ADC_W) - 1;
                return ADC_W'($urandom_range(lo_s, hi_s));
            end
            default:
            begin
                // roughly 0.5 to 35 kohm: s between fs/36 and 2*fs/3
                lo_s = fs / 36;
                hi_s = (2 * fs) / 3 + 1;
                return ADC_W'($urandom_range(lo_s, hi_s));
            end
        endcase
    endfunction

    // Random traffic under the present full scale. With bursts set, send
    // groups of random length separated by random gaps, now and then long
    // enough to land in the middle of a conversion; otherwise chain back to
    // back.
    task automatic run_random_samples(input int unsigned count, input bit bursty);
        int unsigned left_in_burst;
        left_in_burst = $urandom_range(1, 12);
        for (int n = 0; n < count; n++)
        begin
            send_sample(pick_sample(full_scale_shadow));
            if (bursty)
            begin
                left_in_burst--;
                if (left_in_burst == 0)
                begin
                    left_in_burst = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) == 0)
                        pause_sender($urandom_range(20, 70));
                    else
                        pause_sender($urandom_range(0, 15));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset full scale: zero sample, both table ends and the codes that
    // straddle them, and the top of the ADC range.
    task automatic test_reset_scale_corners();
        logic [ADC_W-1:0] corners [10];
        corners = '{12'd0, 12'd1, 12'd120, 12'd121, 12'd122,
                    12'd1000, 12'd2717, 12'd2718, 12'd4094, 12'd4095};
        foreach (corners[k])
            send_sample(corners[k]);
        drain_readings();
    endtask

    // Small full scale: samples above it clamp to zero resistance.
    task automatic test_clamp_above_scale();
        set_full_scale(12'd100);
        send_sample(12'd4095);
        send_sample(12'd101);
        send_sample(12'd100);
        send_sample(12'd50);
        send_sample(12'd3);
        send_sample(12'd1);
        drain_readings();
    endtask

    // Lowest settings: zero full scale must behave as one.
    task automatic test_minimum_scale();
        set_full_scale(12'd0);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd4095);
        set_full_scale(12'd1);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd2);
        drain_readings();
    endtask

    // Random samples across several full-scale settings, extremes included.
    task automatic test_random_scales();
        set_full_scale(12'd4095);
        run_random_samples(RANDOM_PER_SET, 1'b1);
        set_full_scale(12'd2048);
        run_random_samples(RANDOM_PER_SET, 1'b0);
        set_full_scale(thm_pkg::CFG_W'($urandom_range(1, 4095)));
        run_random_samples(RANDOM_PER_SET, 1'b1);
        set_full_scale(12'd1023);
        run_random_samples(RANDOM_PER_SET / 2, 1'b1);
        set_full_scale(12'd1);
        run_random_samples(RANDOM_PER_SET / 6, 1'b1);
        set_full_scale(thm_pkg::CFG_W'($urandom_range(1, 4095)));
        run_random_samples(RANDOM_PER_SET / 2, 1'b0);
        set_full_scale(12'd4095);
        run_random_samples(RANDOM_PER_SET / 2, 1'b1);
        drain_readings();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        start             = 1'b0;
        adc_sample        = '0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        full_scale_shadow = thm_pkg::FS_RESET;
        mismatch_count    = 0;
        samples_sent      = 0;
        readings_checked  = 0;
        inside_seen       = 0;
        cold_seen         = 0;
        hot_seen          = 0;
        scale_writes      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_scale_corners();
        test_clamp_above_scale();
        test_minimum_scale();
        test_random_scales();

        // let any stray strobe show up before judging
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d samples over %0d full-scale writes; checked %0d readings",
                 samples_sent, scale_writes, readings_checked);
        $display("Regions seen: %0d inside table, %0d colder, %0d hotter; %0d mismatches",
                 inside_seen, cold_seen, hot_seen, mismatch_count);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- thermistor_adc_to_temperature.f -----
sv/thm_pkg.sv
sv/thm_sub_unit.sv
sv/thermistor_adc_to_temperature.sv
sv/thm_checker.sv
test/thermistor_adc_to_temperature_tb.sv
